[rtl/core/pcs_pkg.sv]
// types and constants shared by the puct child select block
package pcs_pkg;

  // fixed point format of every score and ratio
  localparam int FRAC_BITS = 16;

  // field widths
  localparam int CW_W    = 24;                     // explore weight, unsigned Q8.16
  localparam int C2_W    = 20;                     // base constant, integer
  localparam int PRIOR_W = 17;                     // prior, unsigned Q1.16
  localparam int VIS_W   = 20;                     // visit counts
  localparam int Q_W     = 24;                     // mean value, signed Q7.16
  localparam int SCORE_W = 40;                     // score, signed Q23.16

  // internal widths
  localparam int ROOT_W    = VIS_W / 2 + FRAC_BITS;  // sqrt(N) in Q.16
  localparam int SUM_W     = VIS_W + 2;              // N + c2 + 1
  localparam int DIV_NUM_W = SUM_W + FRAC_BITS;      // shared divider dividend
  localparam int DIV_DEN_W = VIS_W + 1;              // shared divider divisor
  localparam int MANT_W    = FRAC_BITS + 1;          // log mantissa in [1,2)
  localparam int IP_W      = 5;                      // integer part of log2
  localparam int LOG_W     = IP_W + FRAC_BITS;       // log2 / ln result
  localparam int PS_W      = PRIOR_W + ROOT_W - FRAC_BITS;  // P*sqrt(N)
  localparam int CP_W      = CW_W + PRIOR_W - FRAC_BITS;    // c*P
  localparam int W_W       = CW_W + 1;                      // c + ln(...)
  localparam int TU_W      = CP_W + ROOT_W - FRAC_BITS;     // unvisited term
  localparam int TV_W      = PS_W + W_W - FRAC_BITS;        // visited term

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic [CW_W-1:0] EXPLORE_RESET = 24'd81920;
  localparam logic [C2_W-1:0] BASE_RESET    = 20'd19652;
  localparam logic signed [SCORE_W-1:0] SCORE_NEG_ONE = -40'sd65536;

  // register indexes on the configuration port
  localparam logic REG_EXPLORE = 1'b0;
  localparam logic REG_BASE    = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;         // capture the input item
    logic root_start;   // start the square root unit
    logic ratio_start;  // start divider on (N+c2+1)/c2
    logic mant_load;    // take the ratio as log mantissa
    logic norm_step;    // halve mantissa, bump integer part
    logic log_step;     // one squaring step of the log
    logic ln_mul;       // log2 to ln
    logic ps_mul;       // P*sqrt(N) and c + ln
    logic t1_start;     // start divider on P*sqrt(N)/(1+n)
    logic cp_mul;       // c*P
    logic unvis_mul;    // unvisited score
    logic vis_mul;      // visited score
    logic update;       // running best compare, emit on last
  } pcs_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic root_done;
    logic div_done;
    logic mant_big;
    logic unvis;
  } pcs_status_t;

endpackage

[rtl/core/pcs_sqrt.sv]
// iterative floor square root of value * 2^(2*FRAC), one result bit a cycle
module pcs_sqrt #(
  parameter int IN_W = 20,
  parameter int FRAC = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [IN_W-1:0]               value,
  output logic [(IN_W+2*FRAC)/2-1:0]    root,
  output logic                          done
);

  localparam int RAD_W  = IN_W + 2 * FRAC;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             ge;

  // one trial subtraction per cycle
  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
    trial  = {root, 2'b01};
    ge     = rem_sh >= trial;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= {value, {(2*FRAC){1'b0}}};
      rem  <= '0;
      root <= '0;
    end else if (cnt != '0) begin
      rad  <= rad << 2;
      rem  <= ge ? rem_sh - trial : rem_sh;
      root <= {root[ROOT_W-2:0], ge};
    end
  end

  // step counter and done flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(ROOT_W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        done <= 1'b1;
      end
    end
  end

endmodule

[rtl/core/pcs_div.sv]
// restoring unsigned divider, one quotient bit a cycle
module pcs_div #(
  parameter int NUM_W = 38,
  parameter int DEN_W = 21
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    rem_sh = {rem, quo[NUM_W-1]};
    diff   = rem_sh - {1'b0, den_r};
    ge     = rem_sh >= {1'b0, den_r};
  end

  // payload registers, dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      den_r <= den;
      rem   <= '0;
    end else if (cnt != '0) begin
      quo <= {quo[NUM_W-2:0], ge};
      rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  // step counter and done flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(NUM_W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        done <= 1'b1;
      end
    end
  end

endmodule

[rtl/core/pcs_datapath.sv]
// datapath: operand registers, sqrt and divide units, log, multipliers, running best
module pcs_datapath #(
  parameter int ACTION_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pcs_pkg::pcs_cmd_t                     cmd,
  output pcs_pkg::pcs_status_t                  status,
  input  logic [pcs_pkg::CW_W-1:0]              explore_weight,
  input  logic [pcs_pkg::C2_W-1:0]              base_constant,
  input  logic [ACTION_BITS-1:0]                action,
  input  logic [pcs_pkg::PRIOR_W-1:0]           prior,
  input  logic [pcs_pkg::VIS_W-1:0]             child_visits,
  input  logic signed [pcs_pkg::Q_W-1:0]        child_value,
  input  logic                                  unvisited,
  input  logic [pcs_pkg::VIS_W-1:0]             parent_visits,
  input  logic                                  last,
  output logic [ACTION_BITS-1:0]                pick_action,
  output logic signed [pcs_pkg::SCORE_W-1:0]    best_score,
  output logic                                  found,
  output logic                                  done
);

  localparam int F = pcs_pkg::FRAC_BITS;

  // captured item
  logic [ACTION_BITS-1:0]               action_r;
  logic [pcs_pkg::PRIOR_W-1:0]          prior_r;
  logic [pcs_pkg::VIS_W-1:0]            nvis_r;
  logic signed [pcs_pkg::Q_W-1:0]       q_r;
  logic                                 unvis_r;
  logic [pcs_pkg::VIS_W-1:0]            pvis_r;
  logic                                 last_r;

  // intermediate results
  logic [pcs_pkg::ROOT_W-1:0]           root;
  logic                                 root_done;
  logic [pcs_pkg::DIV_NUM_W-1:0]        quo;
  logic                                 div_done;
  logic [pcs_pkg::DIV_NUM_W-1:0]        mant;
  logic [pcs_pkg::IP_W-1:0]             ip;
  logic [F-1:0]                         fr;
  logic [pcs_pkg::LOG_W-1:0]            ln_r;
  logic [pcs_pkg::PS_W-1:0]             ps;
  logic [pcs_pkg::W_W-1:0]              w;
  logic [pcs_pkg::CP_W-1:0]             cp;
  logic signed [pcs_pkg::SCORE_W-1:0]   score;

  // running best
  logic signed [pcs_pkg::SCORE_W-1:0]   run_score;
  logic [ACTION_BITS-1:0]               run_action;
  logic                                 run_found;

  // combinational helpers
  logic [pcs_pkg::C2_W-1:0]             c2;
  logic [pcs_pkg::SUM_W-1:0]            ratio_sum;
  logic [pcs_pkg::DIV_NUM_W-1:0]        div_num;
  logic [pcs_pkg::DIV_DEN_W-1:0]        div_den;
  logic                                 div_start;
  logic [2*pcs_pkg::MANT_W-1:0]         msq;
  logic [pcs_pkg::MANT_W:0]             msh;
  logic [pcs_pkg::LOG_W+31:0]           ln_prod;
  logic [pcs_pkg::PRIOR_W+pcs_pkg::ROOT_W-1:0] ps_prod;
  logic [pcs_pkg::CW_W+pcs_pkg::PRIOR_W-1:0]   cp_prod;
  logic [pcs_pkg::CP_W+pcs_pkg::ROOT_W-1:0]    tu_prod;
  logic [pcs_pkg::PS_W+pcs_pkg::W_W-1:0]       tv_prod;
  logic signed [pcs_pkg::SCORE_W-1:0]   best_next_score;
  logic [ACTION_BITS-1:0]               best_next_action;
  logic                                 best_next_found;
  logic                                 better;

  // square root of the parent visit count
  pcs_sqrt #(
    .IN_W (pcs_pkg::VIS_W),
    .FRAC (F)
  ) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.root_start),
    .value (pvis_r),
    .root  (root),
    .done  (root_done)
  );

  // divider shared by the log ratio and the visit-count division
  always_comb begin
    c2        = (base_constant == '0) ? pcs_pkg::C2_W'(1) : base_constant;
    ratio_sum = pcs_pkg::SUM_W'(pvis_r) + pcs_pkg::SUM_W'(c2) + pcs_pkg::SUM_W'(1);
    if (cmd.t1_start) begin
      div_num = pcs_pkg::DIV_NUM_W'(ps);
      div_den = pcs_pkg::DIV_DEN_W'(nvis_r) + pcs_pkg::DIV_DEN_W'(1);
    end else begin
      div_num = {ratio_sum, {F{1'b0}}};
      div_den = pcs_pkg::DIV_DEN_W'(c2);
    end
    div_start = cmd.ratio_start | cmd.t1_start;
  end

  pcs_div #(
    .NUM_W (pcs_pkg::DIV_NUM_W),
    .DEN_W (pcs_pkg::DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (quo),
    .done  (div_done)
  );

  // multipliers, each feeding a register
  always_comb begin
    msq     = mant[pcs_pkg::MANT_W-1:0] * mant[pcs_pkg::MANT_W-1:0];
    msh     = msq[2*pcs_pkg::MANT_W-1:F];
    ln_prod = {ip, fr} * pcs_pkg::LN2_Q32;
    ps_prod = prior_r * root;
    cp_prod = explore_weight * prior_r;
    tu_prod = cp * root;
    tv_prod = quo[pcs_pkg::PS_W-1:0] * w;
  end

  // running best compare, strict so the earlier child keeps a tie
  always_comb begin
    better           = score > run_score;
    best_next_score  = better ? score : run_score;
    best_next_action = better ? action_r : run_action;
    best_next_found  = better | run_found;
  end

  // item capture and arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= action;
      prior_r  <= prior;
      nvis_r   <= child_visits;
      q_r      <= child_value;
      unvis_r  <= unvisited;
      pvis_r   <= parent_visits;
      last_r   <= last;
    end
    if (cmd.mant_load) begin
      mant <= quo;
      ip   <= '0;
    end else if (cmd.norm_step) begin
      mant <= mant >> 1;
      ip   <= ip + 1'b1;
    end else if (cmd.log_step) begin
      if (msh[pcs_pkg::MANT_W]) begin
        mant <= pcs_pkg::DIV_NUM_W'(msh[pcs_pkg::MANT_W:1]);
        fr   <= {fr[F-2:0], 1'b1};
      end else begin
        mant <= pcs_pkg::DIV_NUM_W'(msh[pcs_pkg::MANT_W-1:0]);
        fr   <= {fr[F-2:0], 1'b0};
      end
    end
    if (cmd.ln_mul) begin
      ln_r <= ln_prod[pcs_pkg::LOG_W+31:32];
    end
    if (cmd.ps_mul) begin
      ps <= ps_prod[pcs_pkg::PRIOR_W+pcs_pkg::ROOT_W-1:F];
      w  <= pcs_pkg::W_W'(explore_weight) + pcs_pkg::W_W'(ln_r);
    end
    if (cmd.cp_mul) begin
      cp <= cp_prod[pcs_pkg::CW_W+pcs_pkg::PRIOR_W-1:F];
    end
    // both terms stay far inside the 40-bit score range, so no clamp is needed
    if (cmd.unvis_mul) begin
      score <= pcs_pkg::SCORE_W'(tu_prod[pcs_pkg::CP_W+pcs_pkg::ROOT_W-1:F]);
    end else if (cmd.vis_mul) begin
      score <= pcs_pkg::SCORE_W'(q_r)
             + pcs_pkg::SCORE_W'(tv_prod[pcs_pkg::PS_W+pcs_pkg::W_W-1:F]);
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.update && last_r) begin
      pick_action <= best_next_action;
      best_score  <= best_next_score;
      found       <= best_next_found;
    end
  end

  // running best state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      run_score  <= pcs_pkg::SCORE_NEG_ONE;
      run_action <= '0;
      run_found  <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= cmd.update & last_r;
      if (cmd.update) begin
        if (last_r) begin
          run_score  <= pcs_pkg::SCORE_NEG_ONE;
          run_action <= '0;
          run_found  <= 1'b0;
        end else begin
          run_score  <= best_next_score;
          run_action <= best_next_action;
          run_found  <= best_next_found;
        end
      end
    end
  end

  // status to the controller
  always_comb begin
    status.root_done = root_done;
    status.div_done  = div_done;
    status.mant_big  = |mant[pcs_pkg::DIV_NUM_W-1:pcs_pkg::MANT_W];
    status.unvis     = unvis_r;
  end

endmodule

[rtl/core/pcs_ctrl.sv]
// controller: sequences one child through the datapath
module pcs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  pcs_pkg::pcs_status_t status,
  output pcs_pkg::pcs_cmd_t    cmd,
  output logic                 busy
);

  localparam int CNT_W = $clog2(pcs_pkg::FRAC_BITS);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_KICK    = 4'd1;
  localparam logic [3:0] S_WAIT1   = 4'd2;
  localparam logic [3:0] S_NORM    = 4'd3;
  localparam logic [3:0] S_LOG     = 4'd4;
  localparam logic [3:0] S_LN      = 4'd5;
  localparam logic [3:0] S_PS      = 4'd6;
  localparam logic [3:0] S_DIVGO   = 4'd7;
  localparam logic [3:0] S_WAIT2   = 4'd8;
  localparam logic [3:0] S_VIS     = 4'd9;
  localparam logic [3:0] S_CP      = 4'd10;
  localparam logic [3:0] S_UNVIS   = 4'd11;
  localparam logic [3:0] S_UPDATE  = 4'd12;

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_KICK;
        end
      end
      S_KICK: begin
        cmd.root_start  = 1'b1;
        cmd.ratio_start = 1'b1;
        state_next      = S_WAIT1;
      end
      S_WAIT1: begin
        if (status.unvis) begin
          if (status.root_done) begin
            state_next = S_CP;
          end
        end else if (status.root_done && status.div_done) begin
          cmd.mant_load = 1'b1;
          state_next    = S_NORM;
        end
      end
      S_NORM: begin
        if (status.mant_big) begin
          cmd.norm_step = 1'b1;
        end else begin
          cnt_next   = '0;
          state_next = S_LOG;
        end
      end
      S_LOG: begin
        cmd.log_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(pcs_pkg::FRAC_BITS - 1)) begin
          state_next = S_LN;
        end
      end
      S_LN: begin
        cmd.ln_mul = 1'b1;
        state_next = S_PS;
      end
      S_PS: begin
        cmd.ps_mul = 1'b1;
        state_next = S_DIVGO;
      end
      S_DIVGO: begin
        cmd.t1_start = 1'b1;
        state_next   = S_WAIT2;
      end
      S_WAIT2: begin
        if (status.div_done) begin
          state_next = S_VIS;
        end
      end
      S_VIS: begin
        cmd.vis_mul = 1'b1;
        state_next  = S_UPDATE;
      end
      S_CP: begin
        cmd.cp_mul = 1'b1;
        state_next = S_UNVIS;
      end
      S_UNVIS: begin
        cmd.unvis_mul = 1'b1;
        state_next    = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign busy = state != S_IDLE;

endmodule

[rtl/core/puct_child_select_top.sv]
// top level of the puct child select block: config registers, controller and datapath
//
//  channel   handshake              payload
//  -------   ---------------------  ------------------------------------------------
//  item in   start & !busy          action prior child_visits child_value unvisited
//                                   parent_visits last
//  result    done (one cycle)       pick_action best_score found
//  config    psel penable pwrite    paddr pwdata -> explore_weight, base_constant
//
// an unvisited child keeps busy high through the 26-step square root
// a visited child keeps busy high through the 38-step ratio division
// (overlapping the root), one normalise step per integer bit of the log,
// 16 log squarings and a second 38-step division through the shared divider
// rst is synchronous and clears the controller, the running best and the config
// a result is shown for one cycle on done and the receiver cannot stall it
module puct_child_select_top #(
  parameter int ACTION_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [ACTION_BITS-1:0]                action,
  input  logic [pcs_pkg::PRIOR_W-1:0]           prior,
  input  logic [pcs_pkg::VIS_W-1:0]             child_visits,
  input  logic signed [pcs_pkg::Q_W-1:0]        child_value,
  input  logic                                  unvisited,
  input  logic [pcs_pkg::VIS_W-1:0]             parent_visits,
  input  logic                                  last,
  output logic                                  done,
  output logic [ACTION_BITS-1:0]                pick_action,
  output logic signed [pcs_pkg::SCORE_W-1:0]    best_score,
  output logic                                  found,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [2:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  logic [pcs_pkg::CW_W-1:0] explore_weight;
  logic [pcs_pkg::C2_W-1:0] base_constant;
  logic                     wr_en;
  pcs_pkg::pcs_cmd_t        cmd;
  pcs_pkg::pcs_status_t     status;

  // config write transfer, paddr[2] picks the register and the low bits are ignored
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      explore_weight <= pcs_pkg::EXPLORE_RESET;
      base_constant  <= pcs_pkg::BASE_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        pcs_pkg::REG_EXPLORE: explore_weight <= pwdata[pcs_pkg::CW_W-1:0];
        pcs_pkg::REG_BASE:    base_constant  <= pwdata[pcs_pkg::C2_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // config read
  always_comb begin
    case (paddr[2])
      pcs_pkg::REG_EXPLORE: prdata = 32'(explore_weight);
      pcs_pkg::REG_BASE:    prdata = 32'(base_constant);
      default:              prdata = '0;
    endcase
  end

  pcs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  pcs_datapath #(
    .ACTION_BITS (ACTION_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .explore_weight (explore_weight),
    .base_constant  (base_constant),
    .action         (action),
    .prior          (prior),
    .child_visits   (child_visits),
    .child_value    (child_value),
    .unvisited      (unvisited),
    .parent_visits  (parent_visits),
    .last           (last),
    .pick_action    (pick_action),
    .best_score     (best_score),
    .found          (found),
    .done           (done)
  );

endmodule

[rtl/core/pcs_checker.sv]
// port-level checks for the puct child select block, bound to the top level
module pcs_checker #(
  parameter int ACTION_BITS = 8
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic                               done,
  input logic [ACTION_BITS-1:0]             pick_action,
  input logic signed [pcs_pkg::SCORE_W-1:0] best_score,
  input logic                               found
);

  // a result only appears once the item is finished
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item transfer did not raise busy");

  // a result is a single-cycle strobe
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held");

  // no winner leaves the reset best
  a_none_found: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (pick_action == '0 && best_score == pcs_pkg::SCORE_NEG_ONE))
    else $error("empty result carries a score");

  // a winner beat minus one
  a_found_score: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (best_score > pcs_pkg::SCORE_NEG_ONE))
    else $error("winner not above minus one");

endmodule

bind puct_child_select_top pcs_checker #(
  .ACTION_BITS (ACTION_BITS)
) u_pcs_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .pick_action (pick_action),
  .best_score  (best_score),
  .found       (found)
);

[verif/pcs_checker.sv]
`timescale 1ns / 1ps
// checker for the puct child select block: predicts node winners and compares results
module pcs_scoreboard #(
  parameter int ACTION_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic [ACTION_BITS-1:0]             action,
  input  logic [pcs_pkg::PRIOR_W-1:0]        prior,
  input  logic [pcs_pkg::VIS_W-1:0]          child_visits,
  input  logic signed [pcs_pkg::Q_W-1:0]     child_value,
  input  logic                               unvisited,
  input  logic [pcs_pkg::VIS_W-1:0]          parent_visits,
  input  logic                               last,
  input  logic                               done,
  input  logic [ACTION_BITS-1:0]             pick_action,
  input  logic signed [pcs_pkg::SCORE_W-1:0] best_score,
  input  logic                               found,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  input  logic                               pready,
  output int                                 fail_count,
  output int                                 winners_pending,
  output int                                 winners_seen
);
  import pcs_pkg::*;

  localparam logic [63:0] PROD_CAP  = 64'd1 << 62;
  localparam longint      SCORE_TOP = 64'sd549755813887;
  localparam longint      SCORE_BOT = -64'sd549755813888;

  typedef struct {
    logic [ACTION_BITS-1:0]     act;
    logic signed [SCORE_W-1:0]  score;
    logic                       hit;
  } node_winner_t;

  node_winner_t     winner_q[$];
  logic [CW_W-1:0]  weight_c;
  logic [C2_W-1:0]  base_c2;
  longint           best_sc;
  logic [ACTION_BITS-1:0] best_act;
  logic             best_hit;

  // fixed point product shifted by the fraction, capped at 2^62
  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    logic [63:0]  r;
    p = a * b;
    if (p[127:80] != 0) return PROD_CAP;
    r = p[79:16];
    return (r > PROD_CAP) ? PROD_CAP : r;
  endfunction

  // floor square root of n in Q.16
  function automatic logic [63:0] fx_root(logic [63:0] n);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] t;
    x = n << 32;
    r = 0;
    for (int i = 25; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // natural log of a Q.16 value at least one
  function automatic logic [63:0] fx_ln(logic [63:0] x);
    logic [63:0] ip;
    logic [63:0] fr;
    logic [63:0] m;
    ip = 0;
    fr = 0;
    m = x;
    while (m >= (64'd2 << FRAC_BITS)) begin
      m = m >> 1;
      ip++;
    end
    for (int i = 0; i < FRAC_BITS; i++) begin
      m = (m * m) >> FRAC_BITS;
      fr = fr << 1;
      if (m >= (64'd2 << FRAC_BITS)) begin
        m = m >> 1;
        fr = fr | 1;
      end
    end
    return (((ip << FRAC_BITS) | fr) * 64'd2977044472) >> 32;
  endfunction

  // puct score of one child, saturated to the score range
  function automatic longint child_score();
    logic [63:0] root;
    logic [63:0] c2;
    logic [63:0] ratio;
    logic [63:0] w;
    logic [63:0] t1;
    longint      s;
    root = fx_root(64'(parent_visits));
    if (unvisited) begin
      s = longint'(fx_mul(fx_mul(64'(weight_c), 64'(prior)), root));
    end else begin
      c2 = (base_c2 == 0) ? 64'd1 : 64'(base_c2);
      ratio = ((64'(parent_visits) + c2 + 1) << FRAC_BITS) / c2;
      w = 64'(weight_c) + fx_ln(ratio);
      t1 = fx_mul(64'(prior), root) / (64'(child_visits) + 1);
      s = longint'(child_value) + longint'(fx_mul(t1, w));
    end
    if (s > SCORE_TOP) s = SCORE_TOP;
    if (s < SCORE_BOT) s = SCORE_BOT;
    return s;
  endfunction

  assign winners_pending = winner_q.size();

  always @(posedge clk) begin
    longint       s;
    node_winner_t e;
    node_winner_t got;
    if (rst) begin
      weight_c <= EXPLORE_RESET;
      base_c2  <= BASE_RESET;
      best_sc  = -65536;
      best_act = '0;
      best_hit = 1'b0;
      fail_count = 0;
      winners_seen = 0;
      winner_q.delete();
    end else begin
      // register writes on the configuration port
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_EXPLORE) weight_c <= pwdata[CW_W-1:0];
        else base_c2 <= pwdata[C2_W-1:0];
      end
      // child transfer: score and update the running best
      if (start && !busy) begin
        s = child_score();
        if (s > best_sc) begin
          best_sc  = s;
          best_act = action;
          best_hit = 1'b1;
        end
        if (last) begin
          e.act   = best_act;
          e.score = best_sc[SCORE_W-1:0];
          e.hit   = best_hit;
          winner_q.insert(winner_q.size(), e);
          best_sc  = -65536;
          best_act = '0;
          best_hit = 1'b0;
        end
      end
      // result transfer
      if (done) begin
        winners_seen++;
        if (winner_q.size() == 0) begin
          $display("%0t: result with nothing expected: action %0d score %0d found %0b",
                   $time, pick_action, best_score, found);
          fail_count++;
        end else begin
          e = winner_q.pop_front();
          if (pick_action !== e.act) begin
            $display("%0t: pick_action expected %0d actual %0d", $time, e.act, pick_action);
            fail_count++;
          end
          if (best_score !== e.score) begin
            $display("%0t: best_score expected %0d actual %0d", $time, e.score, best_score);
            fail_count++;
          end
          if (found !== e.hit) begin
            $display("%0t: found expected %0b actual %0b", $time, e.hit, found);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// testbench top for the puct child select block: stimulus, config phases and verdict
module tb_top;
  import pcs_pkg::*;

  localparam int ACTION_BITS = 8;
  localparam int STALL_LIMIT = 5000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [ACTION_BITS-1:0]     action;
  logic [PRIOR_W-1:0]         prior;
  logic [VIS_W-1:0]           child_visits;
  logic signed [Q_W-1:0]      child_value;
  logic                       unvisited;
  logic [VIS_W-1:0]           parent_visits;
  logic                       last;
  logic                       done;
  logic [ACTION_BITS-1:0]     pick_action;
  logic signed [SCORE_W-1:0]  best_score;
  logic                       found;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [2:0]                 paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  int fail_count;
  int winners_pending;
  int winners_seen;
  int children_sent;
  int nodes_sent;
  int cfg_phases;
  int quiet_cycles;

  puct_child_select_top #(.ACTION_BITS(ACTION_BITS)) u_dut (.*);

  pcs_scoreboard #(.ACTION_BITS(ACTION_BITS)) u_chk (
    .clk, .rst, .start, .busy, .action, .prior, .child_visits, .child_value,
    .unvisited, .parent_visits, .last, .done, .pick_action, .best_score, .found,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .winners_pending, .winners_seen
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // register write, setup then access
  task automatic reg_write(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drain outstanding winners and let the last child finish before new settings
  task automatic settle_and_configure(input logic [31:0] w, input logic [31:0] c2);
    start <= 1'b0;
    while (winners_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    reg_write(REG_EXPLORE, w);
    reg_write(REG_BASE, c2);
    cfg_phases++;
  endtask

  // child transfer, with a random gap in front unless gaps are off
  task automatic send_child(input logic [7:0] a, input logic [PRIOR_W-1:0] p,
                            input logic [VIS_W-1:0] n, input logic [Q_W-1:0] q,
                            input logic u, input logic [VIS_W-1:0] pn,
                            input logic l, input bit gaps);
    if (gaps && $urandom_range(0, 99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start         <= 1'b1;
    action        <= a;
    prior         <= p;
    child_visits  <= n;
    child_value   <= q;
    unvisited     <= u;
    parent_visits <= pn;
    last          <= l;
    do @(posedge clk); while (busy);
    children_sent++;
    if (l) nodes_sent++;
  endtask

  function automatic logic [PRIOR_W-1:0] rand_prior();
    case ($urandom_range(0, 9))
      0: return PRIOR_W'(0);
      1: return PRIOR_W'(65536);
      2: return PRIOR_W'(65535);
      default: return PRIOR_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [VIS_W-1:0] rand_visits();
    case ($urandom_range(0, 3))
      0: return VIS_W'($urandom_range(0, 20));
      1: return VIS_W'($urandom_range(0, 2000));
      2: return 20'hFFFFF;
      default: return VIS_W'($urandom);
    endcase
  endfunction

  function automatic logic [Q_W-1:0] rand_value();
    case ($urandom_range(0, 4))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return Q_W'($urandom_range(0, 131072) - 65536);
      default: return Q_W'($urandom);
    endcase
  endfunction

  // one node of random children, mostly ascending actions
  task automatic random_node(input bit gaps);
    int          kids;
    logic [7:0]  a;
    logic [VIS_W-1:0] pn;
    bit          noisy;
    kids  = $urandom_range(1, 8);
    noisy = ($urandom_range(0, 9) == 0);
    a     = 8'($urandom_range(0, 40));
    pn    = rand_visits();
    for (int k = 0; k < kids; k++) begin
      if (noisy) begin
        a = 8'($urandom);
        pn = rand_visits();
      end
      send_child(a, rand_prior(), rand_visits(), rand_value(), $urandom_range(0, 3) == 0,
                 pn, k == kids - 1, gaps);
      if (a > 8'd220) a = 8'd255;
      else a = a + 8'($urandom_range(1, 4));
    end
  endtask

  task automatic random_phase(input int items);
    int start_count;
    start_count = children_sent;
    while (children_sent - start_count < items)
      random_node(!(cfg_phases == 1 && children_sent - start_count < 150));
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    action = '0;
    prior = '0;
    child_visits = '0;
    child_value = '0;
    unvisited = 1'b0;
    parent_visits = '0;
    last = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    children_sent = 0;
    nodes_sent = 0;
    cfg_phases = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes with reset settings
    send_child(8'd0, 17'd0, 20'd0, 24'd0, 1'b1, 20'd0, 1'b0, 1'b1);
    send_child(8'd1, 17'd65536, 20'hFFFFF, 24'h7FFFFF, 1'b0, 20'hFFFFF, 1'b0, 1'b1);
    send_child(8'd2, 17'd65535, 20'd0, 24'h800000, 1'b0, 20'hFFFFF, 1'b0, 1'b1);
    send_child(8'd3, 17'd65536, 20'd0, 24'd0, 1'b1, 20'hFFFFF, 1'b1, 1'b1);
    // no child above minus one
    send_child(8'd7, 17'd0, 20'd5, 24'h800000, 1'b0, 20'd9, 1'b1, 1'b1);
    // score exactly minus one does not win
    send_child(8'd9, 17'd0, 20'd1, -24'sd65536, 1'b0, 20'd3, 1'b1, 1'b1);
    // tie, earlier action keeps it
    send_child(8'd5, 17'd30000, 20'd0, 24'd0, 1'b1, 20'd100, 1'b0, 1'b1);
    send_child(8'd6, 17'd30000, 20'd0, 24'd0, 1'b1, 20'd100, 1'b1, 1'b1);
    // visited beats unvisited and top action
    send_child(8'd200, 17'd100, 20'd0, 24'd0, 1'b1, 20'd50, 1'b0, 1'b1);
    send_child(8'd255, 17'd65536, 20'd0, 24'h7FFFFF, 1'b0, 20'd50, 1'b1, 1'b1);
    random_phase(200);

    // zero weight, zero base treated as one
    settle_and_configure(32'd0, 32'd0);
    send_child(8'd1, 17'd65536, 20'd0, 24'd0, 1'b0, 20'hFFFFF, 1'b0, 1'b1);
    send_child(8'd2, 17'd65536, 20'd0, 24'd0, 1'b1, 20'hFFFFF, 1'b1, 1'b1);
    random_phase(250);

    // largest weight and base
    settle_and_configure(32'hFFFFFF, 32'hFFFFF);
    send_child(8'd4, 17'd65536, 20'd0, 24'h7FFFFF, 1'b1, 20'hFFFFF, 1'b0, 1'b1);
    send_child(8'd8, 17'd65536, 20'd0, 24'h7FFFFF, 1'b0, 20'hFFFFF, 1'b1, 1'b1);
    random_phase(200);

    settle_and_configure($urandom_range(0, 24'hFFFFFF), $urandom_range(1, 20'hFFFFF));
    random_phase(200);

    settle_and_configure(32'd65536, 32'd1);
    random_phase(200);

    start <= 1'b0;
    while (winners_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d children in %0d nodes over %0d register settings",
             children_sent, nodes_sent, cfg_phases + 1);
    $display("checked %0d node winners, %0d mismatches", winners_seen, fail_count);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/core/pcs_pkg.sv
rtl/core/pcs_sqrt.sv
rtl/core/pcs_div.sv
rtl/core/pcs_datapath.sv
rtl/core/pcs_ctrl.sv
rtl/core/puct_child_select_top.sv
rtl/core/pcs_checker.sv
verif/pcs_checker.sv
verif/tb_top.sv
